// File: src/fspc_pkg.sv
// ----------------------------------------------------------------------------
// fspc_pkg
// Shared types, constants, step codes and calibration tables of the flywheel
// speed regulator.
// ----------------------------------------------------------------------------
package fspc_pkg;

  localparam int DRIVE_ROWS_DEF = 11;
  localparam int RANGE_ROWS_DEF = 2;
  localparam int ROW_IDX_W      = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_KP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZSB = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RB  = 3'd4;

  localparam logic [15:0] KP_RST  = 16'd128;
  localparam logic [15:0] KI_RST  = 16'd0;
  localparam logic [15:0] KD_RST  = 16'd0;
  localparam logic [16:0] ZSB_RST = 17'd16;
  localparam logic [16:0] RB_RST  = 17'd1600;

  localparam logic [1:0] OP_SPEED = 2'd0;
  localparam logic [1:0] OP_DIST  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = 64;
  localparam int DIV_N_W = 64;
  localparam int DIV_D_W = 40;

  localparam logic [DIV_N_W-1:0] MEAS_NUM  = 64'd60000000;
  localparam logic [DIV_D_W-1:0] I_DEN     = 40'd256000000;
  localparam logic [MUL_B_W-1:0] D_MUL     = 32'd1000000;
  localparam logic [16:0]        SPEED_MAX = 17'd131071;
  localparam logic [15:0]        DRIVE_MAX = 16'd32768;

  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] S_IDLE   = 5'd0;
  localparam logic [STEP_W-1:0] S_DISP   = 5'd1;
  localparam logic [STEP_W-1:0] S_REQ    = 5'd2;
  localparam logic [STEP_W-1:0] S_TGT    = 5'd3;
  localparam logic [STEP_W-1:0] S_FF     = 5'd4;
  localparam logic [STEP_W-1:0] S_MEAS   = 5'd5;
  localparam logic [STEP_W-1:0] S_MEASW  = 5'd6;
  localparam logic [STEP_W-1:0] S_TGTLOW = 5'd7;
  localparam logic [STEP_W-1:0] S_MI     = 5'd8;
  localparam logic [STEP_W-1:0] S_MIW    = 5'd9;
  localparam logic [STEP_W-1:0] S_MP     = 5'd10;
  localparam logic [STEP_W-1:0] S_MPW    = 5'd11;
  localparam logic [STEP_W-1:0] S_MK     = 5'd12;
  localparam logic [STEP_W-1:0] S_MKW    = 5'd13;
  localparam logic [STEP_W-1:0] S_DK     = 5'd14;
  localparam logic [STEP_W-1:0] S_DKW    = 5'd15;
  localparam logic [STEP_W-1:0] S_MD     = 5'd16;
  localparam logic [STEP_W-1:0] S_MDW    = 5'd17;
  localparam logic [STEP_W-1:0] S_MM     = 5'd18;
  localparam logic [STEP_W-1:0] S_MMW    = 5'd19;
  localparam logic [STEP_W-1:0] S_DD     = 5'd20;
  localparam logic [STEP_W-1:0] S_DDW    = 5'd21;
  localparam logic [STEP_W-1:0] S_UPD    = 5'd22;
  localparam logic [STEP_W-1:0] S_DLU    = 5'd23;
  localparam logic [STEP_W-1:0] S_SCAN   = 5'd24;
  localparam logic [STEP_W-1:0] S_IP     = 5'd25;
  localparam logic [STEP_W-1:0] S_IPW    = 5'd26;
  localparam logic [STEP_W-1:0] S_IDV    = 5'd27;
  localparam logic [STEP_W-1:0] S_IDVW   = 5'd28;
  localparam logic [STEP_W-1:0] S_LDONE  = 5'd29;
  localparam logic [STEP_W-1:0] S_OUT    = 5'd30;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [16:0] speed_request;
    logic [15:0] distance_request;
    logic [21:0] pulse_period_us;
    logic [31:0] time_us;
  } in_word_t;

  typedef struct packed {
    logic [15:0] motor_drive;
    logic        speed_ready;
    logic [16:0] measured_speed;
  } out_word_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              take;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       dist_zero;
    logic       period_zero;
    logic       ignore;
    logic       have;
    logic       tgt_low;
    logic       dt_zero;
    logic       cmd_zero;
    logic       cmd_below;
    logic       hit;
    logic       last;
    logic       flat;
    logic       lut_rng;
    logic       mul_busy;
    logic       div_busy;
  } stat_t;

  typedef struct packed {
    logic [16:0] key;
    logic [15:0] val;
  } row_t;

  // rows past the end repeat the last row
  function automatic row_t drive_row(input logic [ROW_IDX_W-1:0] i);
    row_t r;
    case (i)
      5'd0:    r = '{key: 17'd0,     val: 16'd0};
      5'd1:    r = '{key: 17'd3810,  val: 16'd3277};
      5'd2:    r = '{key: 17'd32294, val: 16'd6554};
      5'd3:    r = '{key: 17'd46635, val: 16'd9830};
      5'd4:    r = '{key: 17'd54442, val: 16'd13107};
      5'd5:    r = '{key: 17'd59120, val: 16'd16384};
      5'd6:    r = '{key: 17'd61699, val: 16'd19661};
      5'd7:    r = '{key: 17'd63858, val: 16'd22938};
      5'd8:    r = '{key: 17'd65376, val: 16'd26214};
      5'd9:    r = '{key: 17'd66578, val: 16'd29491};
      default: r = '{key: 17'd67712, val: 16'd32768};
    endcase
    return r;
  endfunction

  function automatic row_t range_row(input logic [ROW_IDX_W-1:0] i);
    row_t r;
    case (i)
      5'd0:    r = '{key: 17'd3072, val: 16'd35872};
      default: r = '{key: 17'd3840, val: 16'd35872};
    endcase
    return r;
  endfunction

endpackage

// File: src/flywheel_speed_pid_controller.sv
// ----------------------------------------------------------------------------
// flywheel_speed_pid_controller
// Flywheel speed regulator: target by speed or by distance table, PID trim on
// encoder speed, drive through an interpolated calibration table.
//
//   channel | direction | handshake           | word
//   in      | input     | in_valid / stall    | in_word_t
//   out     | output    | out_valid / stall   | out_word_t
//   cfg     | input     | cfg_valid / ready   | index + data
//
// One word at a time. A tick is shortest with the target in the dead band and
// a zero period, longest with the full PID pass, set by the serial divider (up
// to four uses: speed, I term, D term, table interpolation) and the shift-add
// multiplier (one multiplier bit per cycle). Set-distance adds the range walk
// and one interpolation. No clearing pass after reset. A stalled result holds
// in the output register while the next word is worked; that word waits at
// hand-off until it drains.
// ----------------------------------------------------------------------------
module flywheel_speed_pid_controller import fspc_pkg::*; #(
  parameter int DRIVE_ROWS = DRIVE_ROWS_DEF,
  parameter int RANGE_ROWS = RANGE_ROWS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  fspc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fspc_dpath #(
    .DRIVE_ROWS (DRIVE_ROWS),
    .RANGE_ROWS (RANGE_ROWS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_word_i   (in_word_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

// File: src/fspc_mul.sv
// ----------------------------------------------------------------------------
// fspc_mul
// Shift-add unsigned multiplier, one multiplier bit per cycle, stops as soon
// as the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module fspc_mul import fspc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic               busy_o,
  output logic [PROD_W-1:0]  prod_o
);

  logic              busy_q;
  logic [PROD_W-1:0] acc_q;
  logic [PROD_W-1:0] a_q;
  logic [MUL_B_W-1:0] b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && b_q == '0) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= PROD_W'(a_i);
      b_q   <= b_i;
    end else if (busy_q && b_q != '0) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule

// File: src/fspc_div.sv
// ----------------------------------------------------------------------------
// fspc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fspc_div import fspc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_N_W-1:0] num_i,
  input  logic [DIV_D_W-1:0] den_i,
  output logic               busy_o,
  output logic [DIV_N_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(DIV_N_W);

  logic               busy_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DIV_D_W-1:0] rem_q;
  logic [DIV_D_W-1:0] den_q;
  logic [DIV_N_W-1:0] quo_q;
  logic [DIV_D_W:0]   sh;
  logic               fit;

  assign sh  = {rem_q, quo_q[DIV_N_W-1]};
  assign fit = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DIV_N_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= fit ? DIV_D_W'(sh - {1'b0, den_q}) : sh[DIV_D_W-1:0];
      quo_q <= {quo_q[DIV_N_W-2:0], fit};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// File: src/fspc_dpath.sv
// ----------------------------------------------------------------------------
// fspc_dpath
// Datapath: configuration, controller state, PID arithmetic, table walk and
// the output word register. Acts on the step code from fspc_ctrl.
// ----------------------------------------------------------------------------
module fspc_dpath import fspc_pkg::*; #(
  parameter int DRIVE_ROWS = DRIVE_ROWS_DEF,
  parameter int RANGE_ROWS = RANGE_ROWS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  input  in_word_t              in_word_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int MAX_ROWS = (DRIVE_ROWS > RANGE_ROWS) ? DRIVE_ROWS : RANGE_ROWS;
  localparam int IDX_W    = $clog2(MAX_ROWS);
  localparam logic [IDX_W-1:0] DRIVE_LAST = IDX_W'(DRIVE_ROWS - 1);
  localparam logic [IDX_W-1:0] RANGE_LAST = IDX_W'(RANGE_ROWS - 1);

  logic [15:0] kp_q, ki_q, kd_q;
  logic [16:0] zsb_q, rb_q;

  logic [16:0] target_q;
  logic [23:0] cmd_q;
  logic [17:0] perr_q;
  logic [31:0] ptime_q;
  logic [47:0] integ_q;
  logic        have_q;
  logic        ready_q;

  in_word_t    item_q;
  logic [16:0] req_q;
  logic [16:0] meas_q;
  logic [17:0] err_q;
  logic [31:0] dt_q;
  logic [49:0] adj_q;
  logic [15:0] drive_q;
  logic [17:0] y_q;
  logic [IDX_W-1:0] idx_q;
  logic        lut_rng_q;
  out_word_t   out_q;

  logic               mul_start, mul_busy;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_prod;
  logic               div_start, div_busy;
  logic [DIV_N_W-1:0] div_n;
  logic [DIV_D_W-1:0] div_d;
  logic [DIV_N_W-1:0] div_q;

  row_t        row_lo, row_hi, row_0;
  logic [24:0] x_cur, key_lo, key_hi, dx;
  logic [16:0] dxk;
  logic [17:0] dy;
  logic [16:0] dy_mag;
  logic        hit, flat, last;

  logic [17:0] err_mag;
  logic [18:0] de;
  logic [18:0] de_mag;
  logic [47:0] integ_mag;
  logic [18:0] delta;
  logic        ignore;
  logic [16:0] meas_sat;
  logic [50:0] isum, csum;
  logic [47:0] integ_sat;
  logic [23:0] cmd_sat;
  logic [49:0] p_mag, q_term;
  logic [17:0] y_interp;

  fspc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .prod_o  (mul_prod)
  );

  fspc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_n),
    .den_i   (div_d),
    .busy_o  (div_busy),
    .quo_o   (div_q)
  );

  // table rows
  always_comb begin
    if (lut_rng_q) begin
      row_lo = range_row(ROW_IDX_W'(idx_q - 1'b1));
      row_hi = range_row(ROW_IDX_W'(idx_q));
      x_cur  = {9'd0, item_q.distance_request};
      last   = idx_q == RANGE_LAST;
    end else begin
      row_lo = drive_row(ROW_IDX_W'(idx_q - 1'b1));
      row_hi = drive_row(ROW_IDX_W'(idx_q));
      x_cur  = {cmd_q[23], cmd_q};
      last   = idx_q == DRIVE_LAST;
    end
  end

  assign row_0  = drive_row('0);
  assign key_lo = {8'd0, row_lo.key};
  assign key_hi = {8'd0, row_hi.key};
  assign hit    = ($signed(x_cur) >= $signed(key_lo)) && ($signed(x_cur) <= $signed(key_hi));
  assign flat   = row_hi.key <= row_lo.key;
  assign dx     = x_cur - key_lo;
  assign dxk    = row_hi.key - row_lo.key;
  assign dy     = {2'b0, row_hi.val} - {2'b0, row_lo.val};
  assign dy_mag = dy[17] ? 17'(-dy) : dy[16:0];
  assign q_term = {33'd0, div_q[16:0]};
  assign y_interp = dy[17] ? ({2'b0, row_lo.val} - q_term[17:0])
                           : ({2'b0, row_lo.val} + q_term[17:0]);

  // PID arithmetic
  assign err_mag   = err_q[17] ? (-err_q) : err_q;
  assign de        = {err_q[17], err_q} - {perr_q[17], perr_q};
  assign de_mag    = de[18] ? (-de) : de;
  assign integ_mag = integ_q[47] ? (-integ_q) : integ_q;
  assign delta     = {2'b0, req_q} - {2'b0, target_q};
  assign ignore    = !(($signed(delta) > $signed({2'b0, zsb_q})) ||
                       ($signed(delta) < -$signed({2'b0, zsb_q})) ||
                       (req_q == '0));
  assign meas_sat  = (div_q[DIV_N_W-1:17] != '0) ? SPEED_MAX : div_q[16:0];

  assign isum = err_q[17] ? ({{3{integ_q[47]}}, integ_q} - {1'b0, mul_prod[49:0]})
                          : ({{3{integ_q[47]}}, integ_q} + {1'b0, mul_prod[49:0]});
  assign integ_sat = (isum[50:47] == {4{isum[47]}}) ? isum[47:0] :
                     (isum[50] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}});
  assign csum = {{27{cmd_q[23]}}, cmd_q} + {adj_q[49], adj_q};
  assign cmd_sat = (csum[50:23] == {28{csum[23]}}) ? csum[23:0] :
                   (csum[50] ? {1'b1, 23'd0} : {1'b0, {23{1'b1}}});
  assign p_mag = {1'b0, mul_prod[56:8]};

  // unit operands
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    case (cmd_i.step)
      S_MI: begin
        mul_start = 1'b1;
        mul_a     = {30'd0, err_mag};
        mul_b     = dt_q;
      end
      S_MP: begin
        mul_start = 1'b1;
        mul_a     = {30'd0, err_mag};
        mul_b     = {16'd0, kp_q};
      end
      S_MK: begin
        mul_start = 1'b1;
        mul_a     = integ_mag;
        mul_b     = {16'd0, ki_q};
      end
      S_MD: begin
        mul_start = 1'b1;
        mul_a     = {29'd0, de_mag};
        mul_b     = {16'd0, kd_q};
      end
      S_MM: begin
        mul_start = 1'b1;
        mul_a     = mul_prod[MUL_A_W-1:0];
        mul_b     = D_MUL;
      end
      S_IP: begin
        mul_start = !flat;
        mul_a     = {23'd0, dx};
        mul_b     = {15'd0, dy_mag};
      end
      S_MEAS: begin
        div_start = item_q.pulse_period_us != '0;
        div_n     = MEAS_NUM;
        div_d     = {18'd0, item_q.pulse_period_us};
      end
      S_DK: begin
        div_start = 1'b1;
        div_n     = mul_prod;
        div_d     = I_DEN;
      end
      S_DD: begin
        div_start = 1'b1;
        div_n     = mul_prod;
        div_d     = {dt_q, 8'd0};
      end
      S_IDV: begin
        div_start = 1'b1;
        div_n     = mul_prod;
        div_d     = {23'd0, dxk};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= KP_RST;
      ki_q     <= KI_RST;
      kd_q     <= KD_RST;
      zsb_q    <= ZSB_RST;
      rb_q     <= RB_RST;
      target_q <= '0;
      cmd_q    <= '0;
      perr_q   <= '0;
      ptime_q  <= '0;
      integ_q  <= '0;
      have_q   <= 1'b0;
      ready_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_KP:  kp_q  <= cfg_data_i[15:0];
          CFG_KI:  ki_q  <= cfg_data_i[15:0];
          CFG_KD:  kd_q  <= cfg_data_i[15:0];
          CFG_ZSB: zsb_q <= cfg_data_i;
          CFG_RB:  rb_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
      case (cmd_i.step)
        S_TGT: begin
          if (!ignore) begin
            target_q <= req_q;
            perr_q   <= '0;
            ptime_q  <= '0;
            integ_q  <= '0;
          end
        end
        S_FF:     cmd_q  <= {7'd0, target_q};
        S_MEAS:   have_q <= 1'b1;
        S_TGTLOW: begin
          if (target_q < zsb_q) begin
            ready_q <= meas_q < rb_q;
          end
        end
        S_MIW: begin
          if (!mul_busy) begin
            integ_q <= integ_sat;
          end
        end
        S_UPD: begin
          cmd_q   <= cmd_sat;
          perr_q  <= err_q;
          ptime_q <= item_q.time_us;
          ready_q <= err_mag < {1'b0, rb_q};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.step)
      S_IDLE: begin
        if (cmd_i.take) begin
          item_q <= in_word_i;
        end
      end
      S_DISP: begin
        req_q     <= (item_q.opcode == OP_SPEED) ? item_q.speed_request : '0;
        lut_rng_q <= 1'b1;
        idx_q     <= IDX_W'(1);
      end
      S_REQ:  req_q  <= (req_q < zsb_q) ? '0 : req_q;
      S_FF:   meas_q <= '0;
      S_MEAS: meas_q <= '0;
      S_MEASW: begin
        if (!div_busy) begin
          meas_q <= meas_sat;
        end
      end
      S_TGTLOW: begin
        drive_q <= '0;
        err_q   <= {1'b0, target_q} - {1'b0, meas_q};
        dt_q    <= item_q.time_us - ptime_q;
      end
      S_MPW: begin
        if (!mul_busy) begin
          adj_q <= err_q[17] ? (-p_mag) : p_mag;
        end
      end
      S_DKW: begin
        if (!div_busy) begin
          adj_q <= integ_q[47] ? (adj_q - div_q[49:0]) : (adj_q + div_q[49:0]);
        end
      end
      S_DDW: begin
        if (!div_busy) begin
          adj_q <= de[18] ? (adj_q - div_q[49:0]) : (adj_q + div_q[49:0]);
        end
      end
      S_DLU: begin
        lut_rng_q <= 1'b0;
        idx_q     <= IDX_W'(1);
        drive_q   <= '0;
        y_q       <= {2'b0, row_0.val};
      end
      S_SCAN: begin
        if (!hit) begin
          if (last) begin
            y_q <= lut_rng_q ? '0 : {2'b0, row_hi.val};
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
      end
      S_IP: begin
        if (flat) begin
          y_q <= {2'b0, row_lo.val};
        end
      end
      S_IDVW: begin
        if (!div_busy) begin
          y_q <= y_interp;
        end
      end
      S_LDONE: begin
        if (lut_rng_q) begin
          req_q <= y_q[17] ? '0 : y_q[16:0];
        end else if (y_q[17]) begin
          drive_q <= '0;
        end else if (y_q[16:0] > {1'b0, DRIVE_MAX}) begin
          drive_q <= DRIVE_MAX;
        end else begin
          drive_q <= y_q[15:0];
        end
      end
      S_OUT: begin
        if (cmd_i.take) begin
          out_q.motor_drive    <= drive_q;
          out_q.speed_ready    <= ready_q;
          out_q.measured_speed <= meas_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat_o.op          = item_q.opcode;
  assign stat_o.dist_zero   = item_q.distance_request == '0;
  assign stat_o.period_zero = item_q.pulse_period_us == '0;
  assign stat_o.ignore      = ignore;
  assign stat_o.have        = have_q;
  assign stat_o.tgt_low     = target_q < zsb_q;
  assign stat_o.dt_zero     = dt_q == '0;
  assign stat_o.cmd_zero    = cmd_q == '0;
  assign stat_o.cmd_below   = $signed({cmd_q[23], cmd_q}) < $signed({8'd0, row_0.key});
  assign stat_o.hit         = hit;
  assign stat_o.last        = last;
  assign stat_o.flat        = flat;
  assign stat_o.lut_rng     = lut_rng_q;
  assign stat_o.mul_busy    = mul_busy;
  assign stat_o.div_busy    = div_busy;

  assign out_word_o = out_q;

endmodule

// File: src/fspc_ctrl.sv
// ----------------------------------------------------------------------------
// fspc_ctrl
// Sequencer: walks one word through dispatch, measurement, PID steps, table
// walk and the output register handoff.
// ----------------------------------------------------------------------------
module fspc_ctrl import fspc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  logic [STEP_W-1:0] state_q, state_d;
  logic              out_valid_q;
  logic              take;

  always_comb begin
    state_d = state_q;
    take    = 1'b0;
    case (state_q)
      S_IDLE: begin
        take = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.op)
          OP_SPEED: state_d = S_REQ;
          OP_DIST:  state_d = stat_i.dist_zero ? S_REQ : S_SCAN;
          OP_TICK:  state_d = S_MEAS;
          default:  state_d = S_IDLE;
        endcase
      end
      S_REQ:    state_d = S_TGT;
      S_TGT:    state_d = stat_i.ignore ? S_IDLE : (stat_i.have ? S_MEAS : S_FF);
      S_FF:     state_d = S_DLU;
      S_MEAS:   state_d = stat_i.period_zero ? S_TGTLOW : S_MEASW;
      S_MEASW:  if (!stat_i.div_busy) state_d = S_TGTLOW;
      S_TGTLOW: state_d = stat_i.tgt_low ? S_OUT : S_MI;
      S_MI:     state_d = S_MIW;
      S_MIW:    if (!stat_i.mul_busy) state_d = S_MP;
      S_MP:     state_d = S_MPW;
      S_MPW:    if (!stat_i.mul_busy) state_d = S_MK;
      S_MK:     state_d = S_MKW;
      S_MKW:    if (!stat_i.mul_busy) state_d = S_DK;
      S_DK:     state_d = S_DKW;
      S_DKW:    if (!stat_i.div_busy) state_d = stat_i.dt_zero ? S_UPD : S_MD;
      S_MD:     state_d = S_MDW;
      S_MDW:    if (!stat_i.mul_busy) state_d = S_MM;
      S_MM:     state_d = S_MMW;
      S_MMW:    if (!stat_i.mul_busy) state_d = S_DD;
      S_DD:     state_d = S_DDW;
      S_DDW:    if (!stat_i.div_busy) state_d = S_UPD;
      S_UPD:    state_d = S_DLU;
      S_DLU: begin
        if (stat_i.cmd_zero) begin
          state_d = S_OUT;
        end else if (stat_i.cmd_below) begin
          state_d = S_LDONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.hit) begin
          state_d = S_IP;
        end else if (stat_i.last) begin
          state_d = S_LDONE;
        end
      end
      S_IP:     state_d = stat_i.flat ? S_LDONE : S_IPW;
      S_IPW:    if (!stat_i.mul_busy) state_d = S_IDV;
      S_IDV:    state_d = S_IDVW;
      S_IDVW:   if (!stat_i.div_busy) state_d = S_LDONE;
      S_LDONE:  state_d = stat_i.lut_rng ? S_REQ : S_OUT;
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          take    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cmd_o.step  = state_q;
  assign cmd_o.take  = take;
  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// File: src/fspc_chk.sv
// ----------------------------------------------------------------------------
// fspc_chk
// Port-level checks of the flywheel speed regulator, bound to the top level.
// ----------------------------------------------------------------------------
module fspc_chk import fspc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input out_word_t             out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("no stall after taking a word");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.motor_drive <= DRIVE_MAX)
    else $error("drive above full scale");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a word in work");

endmodule

bind flywheel_speed_pid_controller fspc_chk u_fspc_chk (.*);

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the flywheel speed regulator. Drives speed, distance
// and tick words under several idle and stall mixes, predicts each result
// with a behavioral copy of the regulator and compares field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import fspc_pkg::*;

  localparam longint CMD_HI   = 64'sd8388607;
  localparam longint CMD_LO   = -64'sd8388608;
  localparam longint INTEG_HI = 64'sd140737488355327;
  localparam longint INTEG_LO = -64'sd140737488355328;
  localparam int     DRAIN_CYC = 1000;
  localparam longint CYC_LIMIT = 64'd4000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  flywheel_speed_pid_controller u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_word_o(out_word),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always #2 clk = ~clk;

  // regulator state
  logic [15:0] kp, ki, kd;
  logic [16:0] zsb, rb;
  logic [16:0] tgt;
  longint      cmd, integ;
  longint      prev_err;
  logic [31:0] prev_t;
  bit          have_meas, rdy;

  out_word_t   exp_q[$];
  int          errors = 0;
  longint      cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_off = 1'b0;

  function automatic longint lerp(longint x0, longint y0, longint x1, longint y1,
                                  longint x);
    if (x1 <= x0) return y0;
    return y0 + ((x - x0) * (y1 - y0)) / (x1 - x0);
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [15:0] drive_of(longint c);
    longint r;
    row_t a, b;
    if (c == 0) return 16'd0;
    a = drive_row('0);
    if (c < longint'(a.key)) r = a.val;
    else begin
      b = drive_row(ROW_IDX_W'(DRIVE_ROWS_DEF - 1));
      r = b.val;
      for (int i = 1; i < DRIVE_ROWS_DEF; i++) begin
        a = drive_row(ROW_IDX_W'(i - 1));
        b = drive_row(ROW_IDX_W'(i));
        if (c >= longint'(a.key) && c <= longint'(b.key)) begin
          r = lerp(a.key, a.val, b.key, b.val, c);
          break;
        end
      end
    end
    return 16'(clampl(r, 0, 32768));
  endfunction

  function automatic logic [16:0] speed_of_distance(logic [15:0] d);
    row_t a, b;
    if (d == 0) return 17'd0;
    for (int i = 1; i < RANGE_ROWS_DEF; i++) begin
      a = range_row(ROW_IDX_W'(i - 1));
      b = range_row(ROW_IDX_W'(i));
      if (d >= a.key && d <= b.key)
        return 17'(clampl(lerp(a.key, a.val, b.key, b.val, d), 0, 131071));
    end
    return 17'd0;
  endfunction

  function automatic longint scale_tz(longint v, longint unsigned mul,
                                      longint unsigned den);
    longint unsigned m, q;
    m = v < 0 ? longint'(-v) : v;
    q = (m * mul) / den;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic out_word_t run_tick(logic [21:0] per, logic [31:0] now);
    out_word_t   o;
    logic [16:0] meas;
    longint      e, adj;
    logic [31:0] dt;
    meas = '0;
    have_meas = 1'b1;
    if (per != 0) meas = (60000000 / per) > 131071 ? 17'd131071 : 17'(60000000 / per);
    o.measured_speed = meas;
    if (tgt < zsb) begin
      o.motor_drive = '0;
      rdy = meas < rb;
    end else begin
      e = longint'(tgt) - longint'(meas);
      dt = now - prev_t;
      integ = clampl(integ + e * longint'(dt), INTEG_LO, INTEG_HI);
      adj = scale_tz(e, kp, 256) + scale_tz(integ, ki, 256000000);
      if (dt != 0)
        adj += scale_tz(e - prev_err, longint'(kd) * 1000000, 256 * longint'(dt));
      cmd = clampl(cmd + adj, CMD_LO, CMD_HI);
      prev_err = e;
      prev_t = now;
      o.motor_drive = drive_of(cmd);
      rdy = (e > -longint'(rb)) && (e < longint'(rb));
    end
    o.speed_ready = rdy;
    return o;
  endfunction

  function automatic bit predict_regulator(in_word_t w, output out_word_t o);
    logic [16:0] req;
    longint      dl;
    o = '0;
    if (w.opcode == OP_TICK) begin
      o = run_tick(w.pulse_period_us, w.time_us);
      return 1;
    end
    if (w.opcode == OP_SPEED) req = w.speed_request;
    else if (w.opcode == OP_DIST) req = speed_of_distance(w.distance_request);
    else return 0;
    if (req < zsb) req = '0;
    dl = longint'(req) - longint'(tgt);
    if (!(dl < -longint'(zsb) || dl > longint'(zsb) || req == 0)) return 0;
    tgt = req;
    prev_err = 0;
    prev_t = '0;
    integ = 0;
    if (have_meas) o = run_tick(w.pulse_period_us, w.time_us);
    else begin
      cmd = longint'(tgt);
      o.motor_drive = drive_of(longint'(tgt));
      o.speed_ready = rdy;
      o.measured_speed = '0;
    end
    return 1;
  endfunction

  task automatic send_word(in_word_t w);
    out_word_t o;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_regulator(w, o)) exp_q.push_back(o);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [16:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_KP:  kp = val[15:0];
      CFG_KI:  ki = val[15:0];
      CFG_KD:  kd = val[15:0];
      CFG_ZSB: zsb = val;
      CFG_RB:  rb = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (exp_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic set_gains(logic [15:0] p, logic [15:0] i, logic [15:0] d,
                           logic [16:0] z, logic [16:0] r);
    wait_idle();
    write_reg(CFG_KP, {1'b0, p});
    write_reg(CFG_KI, {1'b0, i});
    write_reg(CFG_KD, {1'b0, d});
    write_reg(CFG_ZSB, z);
    write_reg(CFG_RB, r);
    write_reg(CFG_NONE, 17'h1ffff);
  endtask

  function automatic in_word_t rand_word(bit noisy);
    in_word_t w;
    w.opcode = noisy ? 2'($urandom_range(3)) :
               ($urandom_range(9) < 7 ? OP_TICK : 2'($urandom_range(1)));
    w.speed_request = $urandom_range(3) == 0 ? 17'($urandom) :
                      17'($urandom_range(70000));
    w.distance_request = $urandom_range(1) ? 16'($urandom_range(3840, 3072)) :
                         16'($urandom);
    case ($urandom_range(3))
      0: w.pulse_period_us = 22'($urandom);
      1: w.pulse_period_us = 22'($urandom_range(2000, 400));
      2: w.pulse_period_us = 22'($urandom_range(8));
      default: w.pulse_period_us = 22'($urandom_range(100000));
    endcase
    w.time_us = $urandom;
    return w;
  endfunction

  task automatic test_directed();
    in_word_t w;
    logic [31:0] t;
    w = '0;
    t = '0;
    w.opcode = OP_SPEED; w.speed_request = 17'd40000; send_word(w);
    w.speed_request = 17'd40005; send_word(w);
    w.speed_request = 17'd5; send_word(w);
    w.opcode = OP_DIST; w.distance_request = 16'd0; send_word(w);
    w.distance_request = 16'd3072; send_word(w);
    w.opcode = OP_UNUSED; send_word(w);
    w.opcode = OP_TICK; w.pulse_period_us = 22'd0; w.time_us = '0; send_word(w);
    w.pulse_period_us = 22'h3fffff; w.time_us = 32'hffffffff; send_word(w);
    w.pulse_period_us = 22'd1; send_word(w);
    w.opcode = OP_DIST; w.distance_request = 16'hffff; send_word(w);
    w.opcode = OP_SPEED; w.speed_request = 17'h1ffff; send_word(w);
    w.distance_request = 16'd3840;
    w.opcode = OP_DIST; send_word(w);
    for (int i = 0; i < 10; i++) begin
      t += 32'd1000;
      w.opcode = OP_TICK; w.time_us = t;
      w.pulse_period_us = 22'($urandom_range(1500, 400));
      send_word(w);
    end
  endtask

  task automatic test_random(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) send_word(rand_word($urandom_range(9) == 0));
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_off = 1'b1;
    send_idle_pct = 0;
    for (int i = 0; i < 6; i++) send_word(rand_word(1'b0));
    wait (!hold_off);
  endtask

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= $urandom_range(99) < recv_stall_pct;
  end

  initial begin : hold_proc
    wait (hold_off);
    repeat (3000) @(negedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (exp_q.size() == 0) begin
        $display("%0t unexpected word %h", $realtime, out_word);
        errors++;
      end else begin
        if (out_word.motor_drive !== exp_q[0].motor_drive) begin
          $display("%0t drive exp %0d got %0d", $realtime, exp_q[0].motor_drive,
                   out_word.motor_drive);
          errors++;
        end
        if (out_word.speed_ready !== exp_q[0].speed_ready) begin
          $display("%0t ready exp %0d got %0d", $realtime, exp_q[0].speed_ready,
                   out_word.speed_ready);
          errors++;
        end
        if (out_word.measured_speed !== exp_q[0].measured_speed) begin
          $display("%0t speed exp %0d got %0d", $realtime,
                   exp_q[0].measured_speed, out_word.measured_speed);
          errors++;
        end
        void'(exp_q.pop_front());
      end
    end
  end

  initial begin
    kp = KP_RST; ki = KI_RST; kd = KD_RST; zsb = ZSB_RST; rb = RB_RST;
    tgt = '0; cmd = 0; integ = 0; prev_err = 0; prev_t = '0;
    have_meas = 0; rdy = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(300, 0, 0);
    set_gains(16'hffff, 16'hffff, 16'hffff, 17'd0, 17'h1ffff);
    test_random(300, 75, 0);
    set_gains(16'd0, 16'd0, 16'd0, 17'h1ffff, 17'd0);
    test_random(200, 0, 75);
    set_gains(16'd300, 16'd40, 16'd2, 17'd16, 17'd1600);
    test_backpressure();
    test_random(500, 22, 22);
    set_gains(16'd64, 16'd500, 16'd20, 17'd200, 17'd800);
    test_random(500, 0, 0);
    wait_idle();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
